### src/indexed_list_insert_remove_core_defines.svh
//------------------------------------------------------------------------------
// Assertion macros for the indexed list core
// Shared property forms used by the core's checks.
//------------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define ILIR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ILIR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### src/ilir_pkg.sv
//------------------------------------------------------------------------------
// ilir_pkg
// Types and constants shared by the indexed list core.
//------------------------------------------------------------------------------
package ilir_pkg;

   localparam int OP_W         = 3;
   localparam int INDEX_W      = 6;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 7;
   localparam int DEPTH_DEF    = 64;
   localparam int WORD_W_DEF   = 32;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND   = 3'd0,
      OP_INSERT   = 3'd1,
      OP_REM_LAST = 3'd2,
      OP_REM_AT   = 3'd3,
      OP_READ     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0] count;
      logic               empty_res;
      status_type         status;
   } rsp_type;

endpackage

### src/ilir_ram.sv
//------------------------------------------------------------------------------
// ilir_ram
// Generic simple dual-port RAM, one write and one registered read port.
//------------------------------------------------------------------------------
module ilir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ilir_seq.sv
//------------------------------------------------------------------------------
// ilir_seq
// Operation sequencer: checks each beat, then streams reads and write-backs
// through the entry RAM to move, fetch or place words.
//------------------------------------------------------------------------------
`include "indexed_list_insert_remove_core_defines.svh"

module ilir_seq #(
   parameter int DEPTH      = ilir_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = ilir_pkg::WORD_W_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [ilir_pkg::OP_W-1:0]               in_op,
   input  logic [ilir_pkg::INDEX_W-1:0]            in_index,
   input  logic [ilir_pkg::VALUE_W-1:0]            in_value,
   output logic                                    res_valid,
   input  logic                                    res_take,
   output ilir_pkg::rsp_type                       res,
   output logic                                    mem_we,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
   output logic [WORD_WIDTH-1:0]                   mem_wdata,
   output logic                                    mem_re,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
   input  logic [WORD_WIDTH-1:0]                   mem_rdata
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int XW   = (CW > ilir_pkg::INDEX_W) ? CW : ilir_pkg::INDEX_W;
   localparam int RV_W = ilir_pkg::VALUE_W;
   localparam int CN_W = ilir_pkg::COUNT_W;

   ilir_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   ilir_pkg::op_type        op_ff, op_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [WORD_WIDTH-1:0]   val_ff, val_in;
   logic [AW-1:0]           rd_addr_ff, rd_addr_in;
   logic [AW-1:0]           wr_addr_ff, wr_addr_in;
   logic [CW-1:0]           reads_ff, reads_in;
   logic                    up_ff, up_in;
   logic                    first_ff, first_in;
   logic                    pend_ff, pend_in;
   logic                    cap_ff, cap_in;
   logic [WORD_WIDTH-1:0]   word_ff, word_in;
   ilir_pkg::status_type    status_ff, status_in;

   ilir_pkg::op_type        op_c;
   ilir_pkg::status_type    status_c;
   logic                    go_c;
   logic [CW-1:0]           count_c;
   logic [AW-1:0]           idx_c;
   logic [AW-1:0]           rd_addr_c;
   logic [AW-1:0]           wr_addr_c;
   logic [CW-1:0]           reads_c;
   logic                    up_c;
   logic                    first_c;
   logic [XW-1:0]           idx_x;
   logic [XW-1:0]           cnt_x;
   logic [XW-1:0]           depth_x;

   logic                    accept;
   logic                    issue;
   logic                    write_shift;
   logic                    finish;
   logic                    ins_final;

   // decode and check the incoming beat against the current count
   always_comb begin
      op_c      = ilir_pkg::op_type'(in_op);
      idx_x     = XW'(in_index);
      cnt_x     = XW'(count_ff);
      depth_x   = XW'(DEPTH);
      status_c  = ilir_pkg::ST_OK;
      go_c      = 1'b0;
      count_c   = count_ff;
      idx_c     = AW'(count_ff);
      rd_addr_c = AW'(count_ff - CW'(1));
      wr_addr_c = AW'(count_ff);
      reads_c   = '0;
      up_c      = 1'b0;
      first_c   = 1'b0;
      case (op_c)
         ilir_pkg::OP_APPEND: begin
            if (cnt_x >= depth_x) begin
               status_c = ilir_pkg::ST_FULL;
            end else begin
               go_c    = 1'b1;
               count_c = count_ff + CW'(1);
            end
         end
         ilir_pkg::OP_INSERT: begin
            if (idx_x > cnt_x) begin
               status_c = ilir_pkg::ST_RANGE;
            end else if (cnt_x >= depth_x) begin
               status_c = ilir_pkg::ST_FULL;
            end else begin
               go_c    = 1'b1;
               count_c = count_ff + CW'(1);
               idx_c   = AW'(in_index);
               reads_c = count_ff - CW'(idx_x);
            end
         end
         ilir_pkg::OP_REM_LAST: begin
            if (count_ff == '0) begin
               status_c = ilir_pkg::ST_EMPTY;
            end else begin
               go_c    = 1'b1;
               count_c = count_ff - CW'(1);
               reads_c = CW'(1);
               first_c = 1'b1;
            end
         end
         ilir_pkg::OP_REM_AT: begin
            if (count_ff == '0) begin
               status_c = ilir_pkg::ST_EMPTY;
            end else if (idx_x >= cnt_x) begin
               status_c = ilir_pkg::ST_RANGE;
            end else begin
               go_c      = 1'b1;
               count_c   = count_ff - CW'(1);
               rd_addr_c = AW'(in_index);
               wr_addr_c = AW'(in_index);
               reads_c   = count_ff - CW'(idx_x);
               up_c      = 1'b1;
               first_c   = 1'b1;
            end
         end
         ilir_pkg::OP_READ: begin
            if (count_ff == '0) begin
               status_c = ilir_pkg::ST_EMPTY;
            end else if (idx_x >= cnt_x) begin
               status_c = ilir_pkg::ST_RANGE;
            end else begin
               go_c      = 1'b1;
               rd_addr_c = AW'(in_index);
               reads_c   = CW'(1);
               first_c   = 1'b1;
            end
         end
         default: begin
            status_c = ilir_pkg::ST_OK;
         end
      endcase
   end

   assign accept      = in_valid && (state_ff == ilir_pkg::S_IDLE);
   assign issue       = (state_ff == ilir_pkg::S_SHIFT) && (reads_ff != '0);
   assign write_shift = (state_ff == ilir_pkg::S_SHIFT) && pend_ff && !cap_ff;
   assign finish      = (state_ff == ilir_pkg::S_SHIFT) && (reads_ff == '0) && !pend_ff;
   assign ins_final   = finish && (op_ff inside {ilir_pkg::OP_APPEND, ilir_pkg::OP_INSERT});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ilir_pkg::S_IDLE: begin
            if (accept) begin
               state_in = go_c ? ilir_pkg::S_SHIFT : ilir_pkg::S_DONE;
            end
         end
         ilir_pkg::S_SHIFT: begin
            if (finish) begin
               state_in = ilir_pkg::S_DONE;
            end
         end
         ilir_pkg::S_DONE: begin
            if (res_take) begin
               state_in = ilir_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ilir_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      in_ready       = (state_ff == ilir_pkg::S_IDLE);
      res_valid      = (state_ff == ilir_pkg::S_DONE);
      res.read_value = RV_W'(word_ff);
      res.count      = CN_W'(count_ff);
      res.empty_res  = (count_ff == '0);
      res.status     = status_ff;
      mem_re         = issue;
      mem_raddr      = rd_addr_ff;
      mem_we         = write_shift || ins_final;
      mem_waddr      = ins_final ? idx_ff : wr_addr_ff;
      mem_wdata      = ins_final ? val_ff : mem_rdata;
   end

   // datapath
   always_comb begin
      count_in   = count_ff;
      op_in      = op_ff;
      idx_in     = idx_ff;
      val_in     = val_ff;
      rd_addr_in = rd_addr_ff;
      wr_addr_in = wr_addr_ff;
      reads_in   = reads_ff;
      up_in      = up_ff;
      first_in   = first_ff;
      pend_in    = 1'b0;
      cap_in     = 1'b0;
      word_in    = word_ff;
      status_in  = status_ff;
      if (accept) begin
         count_in   = count_c;
         op_in      = op_c;
         idx_in     = idx_c;
         val_in     = WORD_WIDTH'(in_value);
         rd_addr_in = rd_addr_c;
         wr_addr_in = wr_addr_c;
         reads_in   = reads_c;
         up_in      = up_c;
         first_in   = first_c;
         word_in    = '0;
         status_in  = status_c;
      end
      if (issue) begin
         rd_addr_in = up_ff ? rd_addr_ff + AW'(1) : rd_addr_ff - AW'(1);
         reads_in   = reads_ff - CW'(1);
         pend_in    = 1'b1;
         cap_in     = first_ff;
         first_in   = 1'b0;
      end
      if (write_shift) begin
         wr_addr_in = up_ff ? wr_addr_ff + AW'(1) : wr_addr_ff - AW'(1);
      end
      if ((state_ff == ilir_pkg::S_SHIFT) && pend_ff && cap_ff) begin
         word_in = mem_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ilir_pkg::S_IDLE;
         count_ff <= '0;
         reads_ff <= '0;
         pend_ff  <= 1'b0;
         cap_ff   <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         reads_ff <= reads_in;
         pend_ff  <= pend_in;
         cap_ff   <= cap_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      val_ff     <= val_in;
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      up_ff      <= up_in;
      word_ff    <= word_in;
      status_ff  <= status_in;
   end

   `ILIR_ASSERT_IMP(a_no_rw_clash, clock, reset, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one entry")
   `ILIR_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "entry count above depth")
   `ILIR_ASSERT_IMP(a_pend_follows_read, clock, reset, pend_ff, $past(mem_re), "read data used without a read")

endmodule

### src/indexed_list_insert_remove_core.sv
//------------------------------------------------------------------------------
// indexed_list_insert_remove_core
// Fixed-capacity ordered word list with append, insert, remove and read.
//
//   channel  dir  beat fields
//   req_     in   op, index, value
//   rsp_     out  read_value, count, empty_res, status
//
// A beat that moves or fetches n entries streams them one entry per cycle
// through the entry RAM's single read and single write port; a rejected
// beat, an append or an unused op moves none. The next beat is accepted
// only once the sequencer has returned to idle.
// Reset is synchronous and empties the list; RAM contents are left as is.
// A stalled response is held in the output register while the next beat
// is processed; the sequencer waits only if a second response is ready.
//------------------------------------------------------------------------------
module indexed_list_insert_remove_core #(
   parameter int DEPTH      = ilir_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = ilir_pkg::WORD_W_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ilir_pkg::OP_W-1:0]     req_op,
   input  logic [ilir_pkg::INDEX_W-1:0]  req_index,
   input  logic [ilir_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ilir_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [ilir_pkg::COUNT_W-1:0]  rsp_count,
   output logic                          rsp_empty_res,
   output logic [1:0]                    rsp_status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                  in_ready;
   logic                  res_valid;
   logic                  res_take;
   ilir_pkg::rsp_type     res;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [WORD_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;
   logic [WORD_WIDTH-1:0] mem_rdata;

   ilir_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   ilir_seq #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_op     (req_op),
      .in_index  (req_index),
      .in_value  (req_value),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   ilir_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_stall = !in_ready;
   assign res_take  = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_take) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_count      = rsp_ff.count;
   assign rsp_empty_res  = rsp_ff.empty_res;
   assign rsp_status     = rsp_ff.status;

endmodule

### dv/ilir_list_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// ilir_list_checker
// Watches the request and response channels of the indexed list core, keeps
// its own copy of the list, works out the response of every accepted request
// beat and compares each accepted response beat with the oldest one waiting.
//------------------------------------------------------------------------------
module ilir_list_checker
   import ilir_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [OP_W-1:0]    req_op,
   input  logic [INDEX_W-1:0] req_index,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [VALUE_W-1:0] rsp_read_value,
   input  logic [COUNT_W-1:0] rsp_count,
   input  logic               rsp_empty_res,
   input  logic [1:0]         rsp_status,
   output int                 mismatches,
   output int                 outstanding
);

   localparam int LIST_DEPTH = DEPTH_DEF;

   logic [VALUE_W-1:0] list_words [0:LIST_DEPTH-1];
   int                 list_len = 0;
   rsp_type            due_rsp_q [$];
   int                 rsp_beats = 0;

   task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                                input logic [31:0] want_v);
      $display("mismatch at response beat %0d: %s got %h expected %h",
               rsp_beats, what, got_v, want_v);
      mismatches++;
   endtask

   task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] word, output rsp_type res);
      logic [VALUE_W-1:0] taken;
      status_type         st;
      int                 pos;
      int                 i;
      taken = '0;
      st    = ST_OK;
      pos   = int'(idx);
      case (op)
         OP_APPEND: begin
            if (list_len >= LIST_DEPTH) begin
               st = ST_FULL;
            end else begin
               list_words[list_len] = word;
               list_len++;
            end
         end
         OP_INSERT: begin
            if (pos > list_len) begin
               st = ST_RANGE;
            end else if (list_len >= LIST_DEPTH) begin
               st = ST_FULL;
            end else begin
               for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = word;
               list_len++;
            end
         end
         OP_REM_LAST: begin
            if (list_len == 0) begin
               st = ST_EMPTY;
            end else begin
               list_len--;
               taken = list_words[list_len];
            end
         end
         OP_REM_AT: begin
            if (list_len == 0) begin
               st = ST_EMPTY;
            end else if (pos >= list_len) begin
               st = ST_RANGE;
            end else begin
               taken = list_words[pos];
               for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         OP_READ: begin
            if (list_len == 0) begin
               st = ST_EMPTY;
            end else if (pos >= list_len) begin
               st = ST_RANGE;
            end else begin
               taken = list_words[pos];
            end
         end
         default: begin
         end
      endcase
      res.read_value = taken;
      res.count      = list_len[COUNT_W-1:0];
      res.empty_res  = (list_len == 0);
      res.status     = st;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         list_len = 0;
         due_rsp_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (due_rsp_q.size() == 0) begin
               flag_mismatch("response with none pending, read_value", rsp_read_value, '0);
            end else begin
               want = due_rsp_q.pop_front();
               if (rsp_read_value !== want.read_value)
                  flag_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_count !== want.count)
                  flag_mismatch("count", 32'(rsp_count), 32'(want.count));
               if (rsp_empty_res !== want.empty_res)
                  flag_mismatch("empty_res", 32'(rsp_empty_res), 32'(want.empty_res));
               if (rsp_status !== want.status)
                  flag_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
            rsp_beats++;
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            apply_list_op(req_op, req_index, req_value, want);
            due_rsp_q.push_back(want);
         end
         outstanding <= due_rsp_q.size();
      end
   end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top
// Stimulus for the indexed list core: a directed run over empty, range and
// unused-op cases, then random fill and drain sequences under several idle
// and stall mixes, a long response hold-off and pauses until all pending
// responses have come back. Checking is done by the list checker.
//------------------------------------------------------------------------------
module tb_top;
   import ilir_pkg::*;

   localparam int LIST_DEPTH  = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES = 100;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [OP_W-1:0]    req_op         = '0;
   logic [INDEX_W-1:0] req_index      = '0;
   logic [VALUE_W-1:0] req_value      = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [VALUE_W-1:0] rsp_read_value;
   logic [COUNT_W-1:0] rsp_count;
   logic               rsp_empty_res;
   logic [1:0]         rsp_status;

   int  chk_fails;
   int  chk_open;
   int  cycle_count = 0;
   int  snd_pct     = 0;
   int  rcv_pct     = 0;
   logic hold_start = 1'b0;
   int  hold_left   = 0;
   int  gen_count   = 0;
   bit  filling     = 1'b1;

   indexed_list_insert_remove_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_status     (rsp_status)
   );

   ilir_list_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_status     (rsp_status),
      .mismatches     (chk_fails),
      .outstanding    (chk_open)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // count down the long response hold-off
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rcv_pct);
   end

   function automatic int count_after(input logic [OP_W-1:0] op,
                                      input logic [INDEX_W-1:0] idx, input int cnt);
      case (op)
         OP_APPEND:   return (cnt < LIST_DEPTH) ? cnt + 1 : cnt;
         OP_INSERT:   return (int'(idx) <= cnt && cnt < LIST_DEPTH) ? cnt + 1 : cnt;
         OP_REM_LAST: return (cnt > 0) ? cnt - 1 : cnt;
         OP_REM_AT:   return (cnt > 0 && int'(idx) < cnt) ? cnt - 1 : cnt;
         default:     return cnt;
      endcase
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] word);
      if ($urandom_range(0, 99) < snd_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(0, 99) < snd_pct);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_index <= idx;
      req_value <= word;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      gen_count = count_after(op, idx, gen_count);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (chk_open != 0);
   endtask

   task automatic random_item(output logic [OP_W-1:0] op, output logic [INDEX_W-1:0] idx,
                              output logic [VALUE_W-1:0] word);
      int pick;
      int hi;
      if (gen_count >= LIST_DEPTH) filling = 1'b0;
      else if (gen_count == 0) filling = 1'b1;
      case ($urandom_range(0, 7))
         0:       word = '0;
         1:       word = '1;
         default: word = $urandom;
      endcase
      if ($urandom_range(0, 99) < 10) begin
         op  = OP_W'($urandom_range(0, 7));
         idx = INDEX_W'($urandom_range(0, 63));
      end else begin
         pick = $urandom_range(0, 99);
         if (filling) begin
            if (pick < 45)      op = OP_APPEND;
            else if (pick < 85) op = OP_INSERT;
            else if (pick < 90) op = OP_REM_LAST;
            else if (pick < 95) op = OP_REM_AT;
            else                op = OP_READ;
         end else begin
            if (pick < 8)       op = OP_APPEND;
            else if (pick < 15) op = OP_INSERT;
            else if (pick < 50) op = OP_REM_LAST;
            else if (pick < 80) op = OP_REM_AT;
            else                op = OP_READ;
         end
         if (op == OP_INSERT) hi = (gen_count > 63) ? 63 : gen_count;
         else                 hi = (gen_count == 0) ? 63 : gen_count - 1;
         if ($urandom_range(0, 3) == 0) idx = INDEX_W'($urandom_range(0, 1) ? hi : 0);
         else                           idx = INDEX_W'($urandom_range(0, hi));
      end
   endtask

   task automatic run_phase(input int n, input int s_pct, input int r_pct);
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] idx;
      logic [VALUE_W-1:0] word;
      snd_pct = s_pct;
      rcv_pct <= r_pct;
      repeat (n) begin
         random_item(op, idx, word);
         send_item(op, idx, word);
      end
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list, range and unused-op cases
      send_item(OP_READ,     6'd0,  32'h0000_0000);
      send_item(OP_REM_LAST, 6'd0,  32'h0000_0000);
      send_item(OP_REM_AT,   6'd0,  32'hFFFF_FFFF);
      send_item(OP_INSERT,   6'd1,  32'h1111_1111);
      send_item(OP_INSERT,   6'd63, 32'hFFFF_FFFF);
      send_item(OP_INSERT,   6'd0,  32'hFFFF_FFFF);
      send_item(OP_APPEND,   6'd63, 32'h0000_0000);
      send_item(OP_APPEND,   6'd0,  32'hA5A5_5A5A);
      send_item(OP_INSERT,   6'd1,  32'h1234_5678);
      send_item(OP_INSERT,   6'd4,  32'h8000_0001);
      send_item(OP_READ,     6'd0,  32'h0000_0000);
      send_item(OP_READ,     6'd4,  32'h0000_0000);
      send_item(OP_READ,     6'd5,  32'h0000_0000);
      send_item(OP_READ,     6'd63, 32'hFFFF_FFFF);
      send_item(OP_REM_AT,   6'd5,  32'h0000_0000);
      send_item(OP_REM_AT,   6'd1,  32'h0000_0000);
      send_item(OP_REM_AT,   6'd0,  32'h0000_0000);
      send_item(OP_SPARE_A,  6'd63, 32'hFFFF_FFFF);
      send_item(OP_SPARE_B,  6'd0,  32'h0000_0000);
      send_item(OP_SPARE_C,  6'd42, 32'h5A5A_A5A5);
      send_item(OP_REM_LAST, 6'd0,  32'h0000_0000);
      send_item(OP_REM_LAST, 6'd0,  32'h0000_0000);
      send_item(OP_REM_LAST, 6'd0,  32'h0000_0000);
      send_item(OP_REM_LAST, 6'd63, 32'hFFFF_FFFF);
      wait_drained();

      run_phase(110, 0, 0);
      run_phase(110, 88, 0);
      run_phase(110, 0, 88);
      run_phase(110, 38, 38);

      // hold responses off while the sender keeps offering beats
      snd_pct = 0;
      rcv_pct <= 0;
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      run_phase(40, 0, 0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (chk_fails == 0 && chk_open == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/ilir_pkg.sv
src/ilir_ram.sv
src/ilir_seq.sv
src/indexed_list_insert_remove_core.sv
dv/ilir_list_checker.sv
dv/tb_top.sv
